/* rtl/fkf_pkg.sv */
// ----------------------------------------------------------------------------
// fkf_pkg: shared types, constants and tables of the key code converter
// Holds the note decode table, the pitch mantissa table built at elaboration
// and the structs that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package fkf_pkg;

	localparam int CLK_W       = 26;
	localparam int MANT_W      = 26;
	localparam int TABLE_LEN   = 768;
	localparam int TABLE_IDX_W = 10;
	localparam int EXP_W       = 4;
	localparam int QBITS       = 61;
	localparam int MANT_FRAC   = 24;
	localparam int Q_W         = 21;
	localparam int CSRC_W      = 42;
	localparam int DEN_W       = 48;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] PITCH_SCALE = 16'd63360;
	localparam logic [21:0] SRC_STD     = 22'd3579545;
	localparam logic [10:0] FNUM_LO     = 11'd1024;
	localparam logic [10:0] FNUM_HI     = 11'd2047;

	localparam logic [0:0] REG_SOURCE_CLOCK = 1'b0;
	localparam logic [0:0] REG_TARGET_CLOCK = 1'b1;

	localparam logic [63:0] QONE = 64'd1 << QBITS;
	localparam logic [63:0] QTWO = 64'd1 << (QBITS + 1);

	typedef logic [MANT_W-1:0] mant_tab_t [TABLE_LEN];

	typedef struct packed {
		logic [EXP_W-1:0]       octave_exp;
		logic [TABLE_IDX_W-1:0] mant_idx;
	} item_t;

	typedef struct packed {
		logic [CLK_W-1:0] source_clock_hz;
		logic [CLK_W-1:0] target_clock_hz;
	} cfg_t;

	// Semitone of each note code; the unused codes take the semitone of the code below.
	function automatic logic [3:0] note_semi(input logic [3:0] code);
		logic [3:0] s;
		case (code)
			4'd0:    s = 4'd0;
			4'd1:    s = 4'd1;
			4'd2:    s = 4'd2;
			4'd3:    s = 4'd2;
			4'd4:    s = 4'd3;
			4'd5:    s = 4'd4;
			4'd6:    s = 4'd5;
			4'd7:    s = 4'd5;
			4'd8:    s = 4'd6;
			4'd9:    s = 4'd7;
			4'd10:   s = 4'd8;
			4'd11:   s = 4'd8;
			4'd12:   s = 4'd9;
			4'd13:   s = 4'd10;
			4'd14:   s = 4'd11;
			default: s = 4'd11;
		endcase
		return s;
	endfunction

	// Truncating Q61 product, capped just above 2.0.
	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		logic [63:0]  r;
		p = {64'd0, a} * {64'd0, b};
		r = p[124:61];
		if (r > QTWO)
			r = QTWO + 64'd1;
		return r;
	endfunction

	function automatic logic [63:0] qpow(input logic [63:0] v, input int n);
		logic [63:0] r;
		logic [63:0] base;
		int          k;
		r = QONE;
		base = v;
		k = n;
		while (k != 0) begin
			if (k % 2 == 1)
				r = qmul(r, base);
			k = k / 2;
			if (k != 0)
				base = qmul(base, base);
		end
		return r;
	endfunction

	// Twelve-tone mantissa table, 2^(m/768) with 24 fractional bits.
	function automatic mant_tab_t build_mant();
		mant_tab_t   t;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] v;
		logic [63:0] sum;
		lo = QONE;
		hi = QTWO;
		while (hi - lo > 64'd1) begin
			mid = lo + ((hi - lo) >> 1);
			if (qpow(mid, TABLE_LEN) <= QTWO)
				lo = mid;
			else
				hi = mid;
		end
		v = QONE;
		for (int m = 0; m < TABLE_LEN; m++) begin
			sum = v + (64'd1 << (QBITS - MANT_FRAC - 1));
			t[m] = sum[QBITS-MANT_FRAC+MANT_W-1:QBITS-MANT_FRAC];
			v = qmul(v, lo);
		end
		return t;
	endfunction

	localparam mant_tab_t MANT = build_mant();

endpackage

/* rtl/fkf_front.sv */
// ----------------------------------------------------------------------------
// fkf_front: input stage
// Accepts key code transactions and splits the pitch into an octave exponent
// and a mantissa table index.
// ----------------------------------------------------------------------------
module fkf_front import fkf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] key_code,
	input  logic [7:0] key_fraction,
	input  logic       queue_full,
	output logic       push,
	output item_t      push_item
);

	logic       valid_s1;
	item_t      item_s1;
	logic       accept;
	logic [3:0] semi;
	logic       wrap;
	logic [3:0] rel;

	assign in_stall  = valid_s1 && queue_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !queue_full;
	assign push_item = item_s1;

	// Pitch counts from three semitones below A; nine and up wrap an octave.
	assign semi = note_semi(key_code[3:0]);
	assign wrap = semi >= 4'd9;
	assign rel  = wrap ? semi - 4'd9 : semi + 4'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.octave_exp <= {1'b0, key_code[6:4]} + {3'd0, wrap};
			item_s1.mant_idx   <= {rel, key_fraction[7:2]};
		end
	end

endmodule

/* rtl/fkf_queue.sv */
// ----------------------------------------------------------------------------
// fkf_queue: decoupling queue
// A short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module fkf_queue import fkf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output item_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

/* rtl/fkf_back.sv */
// ----------------------------------------------------------------------------
// fkf_back: conversion pipeline
// Scales the mantissa by the clock ratio, divides in a pipelined restoring
// divider and picks the lowest block whose frequency number fits.
// ----------------------------------------------------------------------------
module fkf_back import fkf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        queue_not_empty,
	input  item_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  block,
	output logic [10:0] freq_number
);

	localparam int DIV_STAGES = 7;
	localparam int DIV_BITS   = Q_W / DIV_STAGES;
	localparam int N_W        = CSRC_W + MANT_W;
	localparam int NP_W       = N_W + 10;
	// The mantissa carries 24 fraction bits but the pitch scale wants 2^-8.
	localparam int DSH        = MANT_FRAC - 16;
	localparam int REM_W      = DEN_W + DSH + 1;

	logic                   en;
	logic [CSRC_W-1:0]      csrc_q;
	logic [DEN_W-1:0]       den_q;
	logic [CLK_W-1:0]       tgt_nz;
	logic [REM_W-1:0]       dsc;

	logic                   vld_s2, vld_s3, vld_s4, vld_s5;
	logic [MANT_W-1:0]      mant_s2;
	logic [EXP_W-1:0]       exp_s2, exp_s3, exp_s4;
	logic [46:0]            plo_s3, phi_s3;
	logic [N_W-1:0]         n_s4;
	logic                   ovf_s5;
	logic [REM_W-1:0]       rem_s5;
	logic [Q_W-1:0]         low_s5;

	logic                   div_vld_s [DIV_STAGES];
	logic                   div_ovf_s [DIV_STAGES];
	logic [REM_W-1:0]       div_rem_s [DIV_STAGES];
	logic [Q_W-1:0]         div_low_s [DIV_STAGES];
	logic [Q_W-1:0]         div_quo_s [DIV_STAGES];

	logic [MANT_W-1:0]      mant_rd [3];
	logic [MANT_W-1:0]      mant_sel;
	logic [NP_W-1:0]        np;
	logic [Q_W-1:0]         quo;
	logic [Q_W-1:0]         fnum [8];
	logic [2:0]             blk_sel;
	logic [10:0]            fnum_sel;
	logic                   found;

	assign en  = !(out_valid && out_stall);
	assign pop = en && queue_not_empty;

	// Clock dependent factors change only with configuration.
	assign tgt_nz = (cfg.target_clock_hz == '0) ? CLK_W'(1) : cfg.target_clock_hz;

	always_ff @(posedge clk) begin
		csrc_q <= CSRC_W'(PITCH_SCALE * cfg.source_clock_hz);
		den_q  <= DEN_W'(SRC_STD * tgt_nz);
	end

	// Divisor with the mantissa fraction scale folded in.
	assign dsc = REM_W'({den_q, DSH'(0)});

	// Mantissa table, read as three 256-entry banks.
	for (genvar g = 0; g < 3; g++) begin : g_bank
		assign mant_rd[g] = MANT[{2'(g), head.mant_idx[7:0]}];
	end

	always_comb begin
		case (head.mant_idx[9:8])
			2'd0:    mant_sel = mant_rd[0];
			2'd1:    mant_sel = mant_rd[1];
			default: mant_sel = mant_rd[2];
		endcase
	end

	assign np = NP_W'(n_s4) << (exp_s4 + 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s2 <= pop;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mant_s2 <= mant_sel;
			exp_s2  <= head.octave_exp;
			plo_s3  <= 47'(csrc_q[20:0] * mant_s2);
			phi_s3  <= 47'(csrc_q[41:21] * mant_s2);
			exp_s3  <= exp_s2;
			n_s4    <= N_W'({21'd0, plo_s3}) + N_W'({phi_s3, 21'd0});
			exp_s4  <= exp_s3;
			ovf_s5  <= np >= {dsc, Q_W'(0)};
			rem_s5  <= np[REM_W+Q_W-1:Q_W];
			low_s5  <= np[Q_W-1:0];
		end
	end

	// Restoring divider, three quotient bits per stage.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [REM_W-1:0] r_in;
		logic [Q_W-1:0]   l_in;
		logic [Q_W-1:0]   q_in;
		logic             v_in;
		logic             o_in;
		logic [REM_W-1:0] r_out;
		logic [Q_W-1:0]   l_out;
		logic [Q_W-1:0]   q_out;

		if (k == 0) begin : g_first
			assign r_in = rem_s5;
			assign l_in = low_s5;
			assign q_in = '0;
			assign v_in = vld_s5;
			assign o_in = ovf_s5;
		end else begin : g_next
			assign r_in = div_rem_s[k-1];
			assign l_in = div_low_s[k-1];
			assign q_in = div_quo_s[k-1];
			assign v_in = div_vld_s[k-1];
			assign o_in = div_ovf_s[k-1];
		end

		always_comb begin
			r_out = r_in;
			l_out = l_in;
			q_out = q_in;
			for (int j = 0; j < DIV_BITS; j++) begin
				r_out = {r_out[REM_W-2:0], l_out[Q_W-1]};
				l_out = {l_out[Q_W-2:0], 1'b0};
				q_out = {q_out[Q_W-2:0], 1'b0};
				if (r_out >= dsc) begin
					r_out = r_out - dsc;
					q_out[0] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_vld_s[k] <= 1'b0;
			else if (en)
				div_vld_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[k] <= r_out;
				div_low_s[k] <= l_out;
				div_quo_s[k] <= q_out;
				div_ovf_s[k] <= o_in;
			end
		end
	end

	// Quotient carries one extra fractional bit for half-up rounding.
	assign quo = div_ovf_s[DIV_STAGES-1] ? '1 : div_quo_s[DIV_STAGES-1];

	for (genvar b = 0; b < 8; b++) begin : g_blk
		assign fnum[b] = Q_W'(({1'b0, quo >> b} + (Q_W + 1)'(1)) >> 1);
	end

	always_comb begin
		found    = 1'b0;
		blk_sel  = 3'd0;
		fnum_sel = fnum[0][10:0];
		for (int b = 0; b < 8; b++) begin
			if (!found && fnum[b] >= Q_W'(FNUM_LO) && fnum[b] <= Q_W'(FNUM_HI)) begin
				found    = 1'b1;
				blk_sel  = 3'(b);
				fnum_sel = fnum[b][10:0];
			end
		end
		if (!found && fnum[0] >= Q_W'(FNUM_LO)) begin
			blk_sel  = 3'd7;
			fnum_sel = (fnum[7] > Q_W'(FNUM_HI)) ? FNUM_HI : fnum[7][10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= div_vld_s[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			block       <= blk_sel;
			freq_number <= fnum_sel;
		end
	end

endmodule

/* rtl/fm_keycode_to_fnum_block.sv */
// ----------------------------------------------------------------------------
// fm_keycode_to_fnum_block: FM key code to block and frequency number
// Converts a source chip key code and key fraction into the block and
// frequency number of a target chip running from a different clock.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries key_code and key_fraction; a transaction is taken
// at a rising edge with in_valid high and in_stall low. Every input transaction
// yields exactly one output transaction of block and freq_number, delivered in
// order on out_valid / out_stall with the same rule.
// From an accepted input to out_valid the path runs through one front stage,
// the queue entry, and the back stages after the table read, most of them
// set by the seven-stage restoring divider.
// One transaction per cycle is sustained while the output is not stalled.
// A stall on the output freezes the whole back pipeline; the four-entry queue
// then fills before in_stall rises, so the input side keeps running briefly.
// Reset clears all valid flags and the queue and restores both clock
// registers to their defaults; the mantissa table is constant logic, so the
// block is ready as soon as reset is released.
// Clock registers are written through cfg_we / cfg_index / cfg_data and must
// only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module fm_keycode_to_fnum_block import fkf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CLK_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       key_code,
	input  logic [7:0]       key_fraction,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       block,
	output logic [10:0]      freq_number
);

	cfg_t  cfg_q;
	logic  queue_full;
	logic  queue_not_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_clock_hz <= CLK_W'(3579545);
			cfg_q.target_clock_hz <= CLK_W'(7670453);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_CLOCK: cfg_q.source_clock_hz <= cfg_data;
				REG_TARGET_CLOCK: cfg_q.target_clock_hz <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end decodes the pitch and hands it to the queue.
	fkf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_code     (key_code),
		.key_fraction (key_fraction),
		.queue_full   (queue_full),
		.push         (push),
		.push_item    (push_item)
	);

	fkf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head      (head)
	);

	// The back end pulls from the queue whenever its output can move.
	fkf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.queue_not_empty (queue_not_empty),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.block           (block),
		.freq_number     (freq_number)
	);

endmodule

/* rtl/fkf_checker.sv */
// ----------------------------------------------------------------------------
// fkf_checker: port level checks
// Watches the top level ports for output handshake and result range errors.
// ----------------------------------------------------------------------------
module fkf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  block,
	input logic [10:0] freq_number
);

	// A stalled output transaction must stay offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped while stalled");

	// Any block above zero carries a normalized frequency number.
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block != 3'd0 |-> freq_number >= 11'd1024)
		else $error("frequency number below range for nonzero block");

	// Reset empties the pipeline at once.
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind fm_keycode_to_fnum_block fkf_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.block       (block),
	.freq_number (freq_number)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the FM key code converter
// Drives key code / key fraction transactions through several clock settings
// and idling patterns. Each output transaction is checked against an
// independent predictor of the block number and the frequency number.
// ----------------------------------------------------------------------------
module testbench;
	import fkf_pkg::*;

	localparam int      NUM_PHASES  = 8;
	localparam int      PHASE_ITEMS = 250;
	localparam int      SETTLE      = 30;
	localparam int      HOLD_CYCLES = 300;
	localparam longint  CYCLE_LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [CLK_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       key_code;
	logic [7:0]       key_fraction;
	logic             out_valid;
	logic             out_stall;
	logic [2:0]       block;
	logic [10:0]      freq_number;

	fm_keycode_to_fnum_block i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.key_code(key_code), .key_fraction(key_fraction),
		.out_valid(out_valid), .out_stall(out_stall),
		.block(block), .freq_number(freq_number)
	);

	// The bench keeps its own copy of both clock registers.
	logic [CLK_W-1:0] src_hz;
	logic [CLK_W-1:0] tgt_hz;

	// Pitch mantissa table, 2^(m/768) in Q24, built by the bench itself.
	logic [63:0] pitch_mant [768];

	typedef struct packed {
		logic [2:0]  blk;
		logic [10:0] fnum;
	} note_result_t;

	note_result_t pending_notes[$];

	int     send_idle_pct;
	int     recv_stall_pct;
	logic   hold_request;
	logic   holding;
	int     mismatches = 0;
	int     checked = 0;
	int     saturated_hi = 0;
	int     fell_low = 0;
	longint cycles = 0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [63:0] q61_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		logic [63:0]  r;
		p = {64'd0, a} * {64'd0, b};
		r = p[124:61];
		if (r > (64'd1 << 62))
			r = (64'd1 << 62) + 64'd1;
		return r;
	endfunction

	function automatic logic [63:0] q61_pow(input logic [63:0] v, input int unsigned n);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1 << 61;
		sq = v;
		while (n != 0) begin
			if (n[0])
				acc = q61_mul(acc, sq);
			n = n >> 1;
			if (n != 0)
				sq = q61_mul(sq, sq);
		end
		return acc;
	endfunction

	task automatic fill_pitch_mant();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] v;
		lo = 64'd1 << 61;
		hi = 64'd1 << 62;
		while (hi - lo > 64'd1) begin
			mid = lo + (hi - lo) / 2;
			if (q61_pow(mid, 768) <= (64'd1 << 62))
				lo = mid;
			else
				hi = mid;
		end
		v = 64'd1 << 61;
		for (int m = 0; m < 768; m++) begin
			pitch_mant[m] = (v + (64'd1 << 36)) >> 37;
			v = q61_mul(v, lo);
		end
	endtask

	// Rounded frequency number of pitch index y in block b, capped near 2^32.
	function automatic logic [32:0] fnum_in_block(input int unsigned y, input int b);
		int unsigned  e;
		int unsigned  m;
		int           s;
		int           k;
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] quo;
		logic [127:0] rem;
		logic [31:0]  q;
		logic         up;
		e = y / 768;
		m = y % 768;
		den = 128'(22'd3579545) * 128'((tgt_hz == 0) ? 26'd1 : tgt_hz);
		num = 128'(16'd63360) * 128'(src_hz) * 128'(pitch_mant[m]);
		s = int'(e) - b - 8;
		if (s > 0)
			num = num << s;
		quo = num / den;
		rem = num % den;
		if (s < 0) begin
			k = -s;
			up = quo[k-1];
			quo = quo >> k;
		end else begin
			up = (rem >= den - rem);
		end
		q = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
		return {1'b0, q} + 33'(up);
	endfunction

	function automatic note_result_t predict_fnum(input logic [7:0] kc, input logic [7:0] kf);
		logic [3:0]   semi_of [16];
		int unsigned  y;
		logic [32:0]  f;
		note_result_t res;
		semi_of = '{0, 1, 2, 2, 3, 4, 5, 5, 6, 7, 8, 8, 9, 10, 11, 11};
		y = (int'(kc[6:4]) * 12 + int'(semi_of[kc[3:0]]) + 3) * 64 + int'(kf[7:2]);
		for (int b = 0; b < 8; b++) begin
			f = fnum_in_block(y, b);
			if (f >= 1024 && f <= 2047) begin
				res.blk = 3'(b);
				res.fnum = f[10:0];
				return res;
			end
		end
		f = fnum_in_block(y, 0);
		if (f < 1024) begin
			res.blk = 3'd0;
			res.fnum = f[10:0];
			return res;
		end
		f = fnum_in_block(y, 7);
		res.blk = 3'd7;
		res.fnum = (f > 2047) ? 11'd2047 : f[10:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Clock, reset and timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, pending_notes.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: an accepted input transaction enqueues its prediction,
	// an accepted output transaction is checked against the oldest one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		note_result_t want;
		if (arst_n && in_valid && !in_stall)
			pending_notes.push_back(predict_fnum(key_code, key_fraction));
		if (arst_n && out_valid && !out_stall) begin
			if (pending_notes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected output transaction: block %0d fnum %0d",
						block, freq_number);
			end else begin
				want = pending_notes.pop_front();
				checked++;
				if (want.blk == 3'd7 && want.fnum == 11'd2047)
					saturated_hi++;
				if (want.blk == 3'd0 && want.fnum < 11'd1024)
					fell_low++;
				if (block !== want.blk || freq_number !== want.fnum) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected block %0d fnum %0d, got block %0d fnum %0d",
							want.blk, want.fnum, block, freq_number);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request so that the
	// internal queue fills and the block pushes back on its input.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		out_stall <= holding ? 1'b1 : ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		holding = 1'b0;
		forever begin
			@(posedge hold_request);
			@(negedge clk);
			holding = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			@(negedge clk);
			holding = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Sender and configuration tasks
	// ------------------------------------------------------------------
	// Offer one transaction; returns at the falling edge after acceptance.
	task automatic send_key(input logic [7:0] kc, input logic [7:0] kf);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			key_code <= 8'($urandom);
			key_fraction <= 8'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		key_code <= kc;
		key_fraction <= kf;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_notes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write one clock register; only called while nothing is in flight.
	task automatic write_clock(input logic [0:0] idx, input logic [CLK_W-1:0] hz);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= hz;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SOURCE_CLOCK)
			src_hz = hz;
		else
			tgt_hz = hz;
	endtask

	task automatic set_clocks(input logic [CLK_W-1:0] s, input logic [CLK_W-1:0] t);
		if (s != src_hz || t != tgt_hz) begin
			wait_drained();
			write_clock(REG_SOURCE_CLOCK, s);
			write_clock(REG_TARGET_CLOCK, t);
		end
	endtask

	// Directed rows: clocks, key code, key fraction and, where it is obvious,
	// the result. Rows without a typed result go through the predictor only.
	typedef struct {
		logic [CLK_W-1:0] s;
		logic [CLK_W-1:0] t;
		logic [7:0]       kc;
		logic [7:0]       kf;
		bit               typed;
		logic [2:0]       blk;
		logic [10:0]      fnum;
	} key_row_t;

	localparam logic [CLK_W-1:0] SRC_RST = 26'd3579545;
	localparam logic [CLK_W-1:0] TGT_RST = 26'd7670453;
	localparam logic [CLK_W-1:0] HZ_MAX  = 26'h3FFFFFF;

	key_row_t key_rows [] = '{
		'{SRC_RST, TGT_RST, 8'h00, 8'h00, 0, 3'd0, 11'd0},
		'{SRC_RST, TGT_RST, 8'h7E, 8'hFC, 0, 3'd0, 11'd0},
		'{SRC_RST, TGT_RST, 8'hFF, 8'hFF, 0, 3'd0, 11'd0},
		'{SRC_RST, TGT_RST, 8'h43, 8'h00, 0, 3'd0, 11'd0},
		'{SRC_RST, TGT_RST, 8'h47, 8'h80, 0, 3'd0, 11'd0},
		'{SRC_RST, TGT_RST, 8'h4B, 8'h40, 0, 3'd0, 11'd0},
		'{SRC_RST, TGT_RST, 8'h4F, 8'h03, 0, 3'd0, 11'd0},
		'{SRC_RST, TGT_RST, 8'hCA, 8'hAB, 0, 3'd0, 11'd0},
		'{SRC_RST, TGT_RST, 8'h35, 8'h54, 0, 3'd0, 11'd0},
		// Far too high for any block: block 7 saturates.
		'{HZ_MAX,  26'd1,   8'h00, 8'h00, 1, 3'd7, 11'd2047},
		'{HZ_MAX,  26'd1,   8'h7F, 8'hFF, 1, 3'd7, 11'd2047},
		// A zero target clock acts as one.
		'{HZ_MAX,  26'd0,   8'h7E, 8'hFC, 1, 3'd7, 11'd2047},
		// Far too low: block 0 with a value that rounds to nothing.
		'{26'd1,   HZ_MAX,  8'h00, 8'h00, 1, 3'd0, 11'd0},
		'{26'd1,   HZ_MAX,  8'h7F, 8'hFF, 1, 3'd0, 11'd0},
		// A zero source clock gives zero everywhere.
		'{26'd0,   TGT_RST, 8'h7F, 8'hFC, 1, 3'd0, 11'd0},
		'{26'd0,   26'd1,   8'h00, 8'h00, 1, 3'd0, 11'd0},
		'{26'd1,   26'd1,   8'h20, 8'h10, 0, 3'd0, 11'd0},
		'{TGT_RST, SRC_RST, 8'h12, 8'h9C, 0, 3'd0, 11'd0}
	};

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		note_result_t     got;
		logic [CLK_W-1:0] ps;
		logic [CLK_W-1:0] pt;
		cfg_we = 1'b0;
		cfg_index = REG_SOURCE_CLOCK;
		cfg_data = '0;
		in_valid = 1'b0;
		key_code = '0;
		key_fraction = '0;
		hold_request = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		src_hz = SRC_RST;
		tgt_hz = TGT_RST;
		fill_pitch_mant();
		@(posedge arst_n);
		@(negedge clk);

		// Directed part, first with the register defaults from reset.
		foreach (key_rows[i]) begin
			set_clocks(key_rows[i].s, key_rows[i].t);
			if (key_rows[i].typed) begin
				got = predict_fnum(key_rows[i].kc, key_rows[i].kf);
				if (got.blk != key_rows[i].blk || got.fnum != key_rows[i].fnum) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Directed row %0d: expected block %0d fnum %0d, predictor %0d/%0d",
							i, key_rows[i].blk, key_rows[i].fnum, got.blk, got.fnum);
				end
			end
			send_key(key_rows[i].kc, key_rows[i].kf);
		end

		// Random phases, each with its own clock pair and one of four idling patterns.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin ps = SRC_RST; pt = TGT_RST; end
				1: begin ps = HZ_MAX;  pt = HZ_MAX;  end
				2: begin ps = 26'd1;   pt = 26'd1;   end
				3: begin ps = SRC_RST; pt = 26'd0;   end
				default: begin
					// Mostly realistic chip clocks, now and then any value.
					ps = ($urandom_range(3) == 0) ? 26'($urandom)
						: 26'($urandom_range(8000000, 1000000));
					pt = ($urandom_range(3) == 0) ? 26'($urandom)
						: 26'($urandom_range(8000000, 1000000));
				end
			endcase
			set_clocks(ps, pt);
			wait_drained();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 4 && n == 10)
					hold_request <= 1'b1;
				if (ph == 4 && n == 11)
					hold_request <= 1'b0;
				send_key(8'($urandom), 8'($urandom));
			end
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		$display("Checked %0d conversions over the directed clock settings, %0d random phases",
			checked, NUM_PHASES);
		$display("and four idling patterns, with %0d saturated high, %0d below range and a hold-off.",
			saturated_hi, fell_low);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
